// ===== rtl/tpsc_pkg.sv =====
// shared types, constants and helpers of the tachometer speed regulator
package tpsc_pkg;

  // configuration port geometry
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned REG_W  = 16;

  // register indexes on the configuration port
  localparam logic [2:0] REG_DESIRED = 3'd0;
  localparam logic [2:0] REG_KP_NUM  = 3'd1;
  localparam logic [2:0] REG_KP_DEN  = 3'd2;
  localparam logic [2:0] REG_KI_NUM  = 3'd3;
  localparam logic [2:0] REG_KI_DEN  = 3'd4;

  // request operation codes
  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // measurement and clamp constants
  localparam int unsigned STAMP_W     = 24;
  localparam int unsigned SPEED_W     = 10;
  localparam int unsigned TICK_W      = 2;
  localparam logic [TICK_W-1:0] STALL_TICKS = 2'd3;
  localparam logic [STAMP_W-1:0] STAMP_RESET = 24'hFF_FFFF;
  localparam logic [STAMP_W-1:0] MIN_PERIOD  = 24'd200000;
  localparam logic [31:0] SPEED_SCALE = 32'd200000000;
  localparam logic [15:0] DUTY_MAX    = 16'd39990;

  // shared divider geometry
  localparam int unsigned DIVD_W    = 32;
  localparam int unsigned DIVS_W    = 24;
  localparam int unsigned DIV_CNT_W = $clog2(DIVD_W);

  // configuration register set
  typedef struct packed {
    logic [REG_W-1:0] desired_speed;
    logic [REG_W-1:0] kp_num;
    logic [REG_W-1:0] kp_den;
    logic [REG_W-1:0] ki_num;
    logic [REG_W-1:0] ki_den;
  } cfg_t;

  // divider start request
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SPEED  = 7'b0000010,
    ST_MUL_P  = 7'b0000100,
    ST_DIV_P  = 7'b0001000,
    ST_MUL_I  = 7'b0010000,
    ST_DIV_I  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  // clamp a signed sum into the duty range
  function automatic logic [15:0] clamp_duty(logic signed [33:0] v);
    logic [15:0] r;
    if (v[33]) begin
      r = 16'd0;
    end else if (v > $signed({18'd0, DUTY_MAX})) begin
      r = DUTY_MAX;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // a zero denominator acts as one
  function automatic logic [DIVS_W-1:0] fix_den(logic [REG_W-1:0] d);
    logic [DIVS_W-1:0] r;
    if (d == '0) begin
      r = DIVS_W'(1);
    end else begin
      r = {{(DIVS_W-REG_W){1'b0}}, d};
    end
    return r;
  endfunction

endpackage

// ===== rtl/tpsc_regs.sv =====
// configuration register file behind the apb-style port
module tpsc_regs
  import tpsc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;

  // register writes, upper data bits ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.desired_speed <= '0;
      cfg_q.kp_num        <= '0;
      cfg_q.kp_den        <= REG_W'(1);
      cfg_q.ki_num        <= '0;
      cfg_q.ki_den        <= REG_W'(1);
    end else if (wr_en) begin
      case (idx)
        REG_DESIRED: cfg_q.desired_speed <= pwdata[REG_W-1:0];
        REG_KP_NUM:  cfg_q.kp_num        <= pwdata[REG_W-1:0];
        REG_KP_DEN:  cfg_q.kp_den        <= pwdata[REG_W-1:0];
        REG_KI_NUM:  cfg_q.ki_num        <= pwdata[REG_W-1:0];
        REG_KI_DEN:  cfg_q.ki_den        <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_DESIRED: prdata = {{(DATA_W-REG_W){1'b0}}, cfg_q.desired_speed};
      REG_KP_NUM:  prdata = {{(DATA_W-REG_W){1'b0}}, cfg_q.kp_num};
      REG_KP_DEN:  prdata = {{(DATA_W-REG_W){1'b0}}, cfg_q.kp_den};
      REG_KI_NUM:  prdata = {{(DATA_W-REG_W){1'b0}}, cfg_q.ki_num};
      REG_KI_DEN:  prdata = {{(DATA_W-REG_W){1'b0}}, cfg_q.ki_den};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/tpsc_div.sv =====
// shared restoring divider, one quotient bit per cycle
module tpsc_div
  import tpsc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  output div_stat_t         stat_o,
  output logic [DIVD_W-1:0] quot_o
);

  logic [DIVS_W-1:0]    rem_q, rem_d;
  logic [DIVD_W-1:0]    quot_q;
  logic [DIVS_W-1:0]    dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DIVS_W:0]      trial, diff;
  logic                 qbit;

  // one trial subtraction per step
  assign trial = {rem_q, quot_q[DIVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = (trial >= {1'b0, dvs_q});
  assign rem_d = qbit ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];

  // step counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quot_q <= req_i.dividend;
      dvs_q  <= req_i.divisor;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[DIVD_W-2:0], qbit};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

// ===== rtl/tach_pi_speed_controller_core.sv =====
// tachometer speed measurement and pi regulator, top level with sequencer
// a capture only runs a divider pass when the speed is recomputed
// a tick runs two divider passes (32 steps and a done flag each), a multiply step before each
// and a final sum step
// no new request is taken until the current one is done; a tick also waits for a pending result
// reset (async, active low) restores the register defaults, clears the state, last stamp all ones
module tach_pi_speed_controller_core
  import tpsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [STAMP_W-1:0] capture_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        duty_o,
  output logic signed [32:0] prop_term_o,
  output logic [15:0]        integral_term_o,
  output logic [SPEED_W-1:0] measured_speed_o
);

  cfg_t              cfg;
  div_req_t          div_req;
  div_stat_t         div_stat;
  logic [DIVD_W-1:0] quot;

  state_e              state_q, state_d;
  logic [STAMP_W-1:0]  last_q, last_d;
  logic [SPEED_W-1:0]  speed_q, speed_d;
  logic [TICK_W-1:0]   ticks_q, ticks_d;
  logic [15:0]         acc_q, acc_d;
  logic                out_valid_q, out_valid_d;
  logic signed [16:0]  err_q, err_d;
  logic                neg_q;
  logic signed [32:0]  up_q, up_d;
  logic [15:0]         duty_q, int_q;
  logic signed [32:0]  prop_q;
  logic [SPEED_W-1:0]  mspd_q;

  logic                accept, out_free, load_out;
  logic [STAMP_W-1:0]  period;
  logic [TICK_W-1:0]   ticks_inc;
  logic [SPEED_W-1:0]  speed_tick;
  logic [15:0]         gain;
  logic signed [33:0]  prod;
  logic [33:0]         prod_mag;
  logic signed [32:0]  scaled;
  logic signed [33:0]  sum_i, sum_u;

  tpsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tpsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quot_o (quot)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // period since the last edge, modulo the timer width
  assign period = last_q - capture_time_i;

  // tick count and stall detection
  assign ticks_inc  = (ticks_q < STALL_TICKS) ? ticks_q + 1'b1 : ticks_q;
  assign speed_tick = (ticks_inc >= STALL_TICKS) ? '0 : speed_q;

  // shared gain multiplier, magnitude goes to the divider
  assign gain     = (state_q == ST_MUL_I) ? cfg.ki_num : cfg.kp_num;
  assign prod     = $signed({1'b0, gain}) * err_q;
  assign prod_mag = prod[33] ? 34'(-prod) : prod;

  // signed quotient of the last division
  assign scaled = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  assign sum_i = $signed({18'd0, acc_q}) + {scaled[32], scaled};
  assign sum_u = {up_q[32], up_q} + $signed({18'd0, acc_q});

  // sequencer
  always_comb begin
    state_d          = state_q;
    last_d           = last_q;
    speed_d          = speed_q;
    ticks_d          = ticks_q;
    acc_d            = acc_q;
    err_d            = err_q;
    up_d             = up_q;
    out_valid_d      = out_valid_q;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_mag[DIVD_W-1:0];
    div_req.divisor  = fix_den(cfg.kp_den);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OP_CAPTURE) begin
            last_d  = capture_time_i;
            ticks_d = '0;
            if ((ticks_q < STALL_TICKS) && (period > MIN_PERIOD)) begin
              div_req.start    = 1'b1;
              div_req.dividend = SPEED_SCALE;
              div_req.divisor  = period;
              state_d          = ST_SPEED;
            end
          end else begin
            ticks_d = ticks_inc;
            speed_d = speed_tick;
            err_d   = $signed({1'b0, cfg.desired_speed}) -
                      $signed({7'd0, speed_tick});
            state_d = ST_MUL_P;
          end
        end
      end
      ST_SPEED: begin
        if (div_stat.done) begin
          speed_d = quot[SPEED_W-1:0];
          state_d = ST_IDLE;
        end
      end
      ST_MUL_P: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV_P;
      end
      ST_DIV_P: begin
        if (div_stat.done) begin
          up_d    = scaled;
          state_d = ST_MUL_I;
        end
      end
      ST_MUL_I: begin
        div_req.start   = 1'b1;
        div_req.divisor = fix_den(cfg.ki_den);
        state_d         = ST_DIV_I;
      end
      ST_DIV_I: begin
        if (div_stat.done) begin
          acc_d   = clamp_duty(sum_i);
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= STAMP_RESET;
      speed_q     <= '0;
      ticks_q     <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      speed_q     <= speed_d;
      ticks_q     <= ticks_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working values and result register
  always_ff @(posedge clk_i) begin
    err_q <= err_d;
    up_q  <= up_d;
    if ((state_q == ST_MUL_P) || (state_q == ST_MUL_I)) begin
      neg_q <= prod[33];
    end
    if (load_out) begin
      duty_q <= clamp_duty(sum_u);
      prop_q <= up_q;
      int_q  <= acc_q;
      mspd_q <= speed_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign duty_o           = duty_q;
  assign prop_term_o      = prop_q;
  assign integral_term_o  = int_q;
  assign measured_speed_o = mspd_q;

  // divider is only started when free
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_stat.busy)
    else $error("divider started while busy");

  // a tick request moves on to the proportional multiply
  a_tick_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (operation_i == OP_TICK)) |=> (state_q == ST_MUL_P))
    else $error("tick request did not start the controller step");

  // clamped values stay in range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((duty_o <= DUTY_MAX) && (integral_term_o <= DUTY_MAX)))
    else $error("result outside duty range");

  // measured speed stays below one thousand
  a_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_q < SPEED_W'(1000))
    else $error("measured speed out of range");

  // a finished result is never overwritten before it is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !load_out)
    else $error("pending result overwritten");

endmodule
